>>> src/sha256_stream_hasher_top_defines.svh
// Assertion macros for the hasher
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// property must hold at every edge outside reset
`define SHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// after antecedent, consequent holds next cycle
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } sha_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       wr_byte;
        logic [7:0] wr_data;
        logic       count_len;
        logic       start_round;
        logic       do_round;
        logic       fold;
        logic       init;
        logic       pad_marked;
    } sha_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } sha_stat_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

>>> src/sha_datapath.sv
`timescale 1ns / 1ps
module sha_datapath
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_cmd_t    cmd,
    input  logic [2:0]  out_sel,
    output sha_stat_t   stat,
    output logic [31:0] hash_word
);
    // block buffer doubles as the 16-word message schedule window
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [63:0] len_reg, len_next;

    logic [31:0] s0, s1, t1, t2, ch, mj, e0, e1, wn;

    // length word written when padding reaches the length slot
    logic [63:0] bits;
    assign bits = {len_reg[60:0], 3'b000};

    assign stat.fill  = fill_reg;
    assign stat.round = round_reg;
    assign hash_word  = h_reg[out_sel];

    always_comb
    begin
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        e1 = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + e1 + ch + K_TAB[round_reg] + w_reg[0];
        e0 = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = e0 + mj;

        w_next     = w_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        len_next   = len_reg;

        if (cmd.count_len)
            len_next = len_reg + 64'd1;

        if (cmd.wr_byte)
        begin
            // big-endian byte lane within the word
            unique case (fill_reg[1:0])
                2'd0: w_next[fill_reg[5:2]][31:24] = cmd.wr_data;
                2'd1: w_next[fill_reg[5:2]][23:16] = cmd.wr_data;
                2'd2: w_next[fill_reg[5:2]][15:8]  = cmd.wr_data;
                default: w_next[fill_reg[5:2]][7:0] = cmd.wr_data;
            endcase
            fill_next = fill_reg + 6'd1;
        end

        if (cmd.pad_marked)
        begin
            w_next[14] = bits[63:32];
            w_next[15] = bits[31:0];
        end

        if (cmd.start_round)
        begin
            v_next     = h_reg;
            round_next = '0;
        end

        if (cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15] = wn;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            round_next = round_reg + 6'd1;
        end

        if (cmd.fold)
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + v_reg[i];

        if (cmd.init)
        begin
            h_next    = H_INIT;
            fill_next = '0;
            len_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg     <= H_INIT;
            fill_reg  <= '0;
            round_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            h_reg     <= h_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end
endmodule

>>> src/sha_ctrl.sv
`timescale 1ns / 1ps
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       last_item,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_sel,
    output logic       out_last,
    input  sha_stat_t  stat,
    output sha_cmd_t   cmd
);
    sha_state_t state_reg, state_next;
    logic       final_reg, final_next;   // last item taken, digest follows padding
    logic       mark_reg, mark_next;     // 0x80 already placed
    logic [2:0] idx_reg, idx_next;

    assign out_sel  = idx_reg;
    assign out_last = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            mark_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            mark_reg  <= mark_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        logic acc;
        acc        = 1'b0;
        state_next = state_reg;
        final_next = final_reg;
        mark_next  = mark_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                acc = in_valid;
                if (acc && byte_valid)
                begin
                    cmd.wr_byte   = 1'b1;
                    cmd.wr_data   = data_byte;
                    cmd.count_len = 1'b1;
                end
                if (acc)
                begin
                    if (byte_valid && stat.fill == 6'd63)
                    begin
                        cmd.start_round = 1'b1;
                        state_next = ST_ROUND;
                        final_next = 1'b0;
                        mark_next  = 1'b0;
                        if (last_item)
                            state_next = ST_ROUND;
                    end
                    if (last_item)
                        final_next = 1'b1;
                    if (last_item && !(byte_valid && stat.fill == 6'd63))
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (stat.round == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (mark_reg && stat.fill == LEN_POS && idx_reg == 3'd1)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
                idx_next = '0;
            end
            ST_PAD:
            begin
                // idx_reg == 1 tracks whether the length block was just compressed
                cmd.wr_byte = 1'b1;
                cmd.wr_data = mark_reg ? 8'h00 : PAD_MARK;
                mark_next   = 1'b1;
                if (mark_reg && stat.fill == LEN_POS)
                begin
                    cmd.pad_marked  = 1'b1;
                    cmd.wr_byte     = 1'b0;
                    cmd.start_round = 1'b1;
                    idx_next        = 3'd1;
                    state_next      = ST_ROUND;
                end
                else if (stat.fill == 6'd63)
                begin
                    cmd.start_round = 1'b1;
                    state_next      = ST_ROUND;
                end
            end
            default:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.init   = 1'b1;
                        final_next = 1'b0;
                        mark_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end
endmodule

>>> src/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// SHA-256 byte-stream hasher. At most one message byte is taken per item; the item that
// fills a block runs 64 compression rounds plus a fold on a single shared round unit
// before the next item is taken. A last item pads byte by byte up to byte 56, loads the
// length, then runs 64 rounds and a fold; when the 0x80 mark lands at byte 56 or later,
// the pad first runs to byte 63 and that block takes its own compression. The eight digest
// words then stream out, index 0 first, one per accepted cycle, and the block
// reinitializes for the next message.
`include "sha256_stream_hasher_top_defines.svh"
module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    sha_cmd_t  cmd;
    sha_stat_t stat;
    logic [2:0] sel;

    sha_ctrl u_ctrl (
        .clk, .rst_n, .data_byte, .byte_valid, .last_item, .in_valid, .in_ready,
        .out_valid, .out_ready, .out_sel(sel), .out_last(last_word), .stat, .cmd
    );

    sha_datapath u_dp (
        .clk, .rst_n, .cmd, .out_sel(sel), .stat, .hash_word(digest_word)
    );

    assign word_index = sel;

    `SHA_ASSERT(a_no_overlap, !(in_ready && out_valid), "input and output both open")
    `SHA_ASSERT(a_last_idx, !(out_valid && last_word) || word_index == 3'd7, "last off word 7")
    `SHA_ASSERT_NEXT(a_wrap, out_valid && out_ready && last_word, in_ready, "no idle after digest")
endmodule

>>> tb/sv/tb_sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
module tb_sha256_stream_hasher_top;
    import sha_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_item;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_stream_hasher_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .byte_valid(byte_valid), .last_item(last_item),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predictor state
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned blk_fill;
    logic [63:0] byte_count;

    msg_item_t   pending_items [$];
    digest_out_t expected_words [$];
    int          errors;
    int          words_seen;
    int          msgs_sent;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] a [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                 + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
        for (int i = 0; i < 8; i++)
            a[i] = chain[i];
        for (int r = 0; r < 64; r++)
        begin
            t1 = a[7] + (rotr(a[4], 6) ^ rotr(a[4], 11) ^ rotr(a[4], 25))
               + ((a[4] & a[5]) ^ (~a[4] & a[6])) + ROUND_K[r] + w[r];
            t2 = (rotr(a[0], 2) ^ rotr(a[0], 13) ^ rotr(a[0], 22))
               + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
            a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
            a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += a[i];
    endtask

    task automatic append_byte(input logic [7:0] b);
        blk[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64)
        begin
            compress_blk();
            blk_fill = 0;
        end
    endtask

    task automatic restart_digest();
        for (int i = 0; i < 8; i++)
            chain[i] = IV_WORDS[i];
        blk_fill   = 0;
        byte_count = '0;
    endtask

    task automatic predict_item(input msg_item_t it);
        logic [63:0] bits;
        digest_out_t d;
        if (it.has_byte)
        begin
            byte_count++;
            append_byte(it.data);
        end
        if (it.last)
        begin
            bits = byte_count << 3;
            append_byte(PAD_MARK);
            while (blk_fill != LEN_POS)
                append_byte(8'h00);
            for (int k = 0; k < 8; k++)
                append_byte(bits[56-8*k +: 8]);
            for (int k = 0; k < 8; k++)
            begin
                d.word = chain[k];
                d.idx  = k[2:0];
                d.last = (k == 7);
                expected_words.push_back(d);
            end
            restart_digest();
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'h00;
            byte_valid <= 1'b0;
            last_item  <= 1'b0;
            in_gap     = 0;
        end
        else
        begin
            if (!in_valid || in_ready)
            begin
                if (in_valid)
                    predict_item({data_byte, byte_valid, last_item});
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    msg_item_t it;
                    it = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    data_byte  <= it.data;
                    byte_valid <= it.has_byte;
                    last_item  <= it.last;
                    in_gap = gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected digest word %h idx %0d", $time,
                             digest_word, word_index);
                end
                else
                begin
                    digest_out_t e;
                    e = expected_words.pop_front();
                    if (e.word !== digest_word)
                    begin
                        errors++;
                        $display("%0t: digest_word exp %h got %h", $time, e.word, digest_word);
                    end
                    if (e.idx !== word_index)
                    begin
                        errors++;
                        $display("%0t: word_index exp %0d got %0d", $time, e.idx, word_index);
                    end
                    if (e.last !== last_word)
                    begin
                        errors++;
                        $display("%0t: last_word exp %0b got %0b", $time, e.last, last_word);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap = gap_len();
            end
        end
    end

    task automatic add_msg(input int len, input bit mode_ff, input bit empty_tail);
        msg_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.data = mode_ff ? 8'hff : 8'($urandom);
            it.has_byte = 1'b1;
            it.last = (i == len - 1) && !empty_tail;
            pending_items.push_back(it);
            // occasional ignored item with garbage data mid-message
            if ($urandom_range(0, 15) == 0)
                pending_items.push_back({8'($urandom), 1'b0, 1'b0});
        end
        if (empty_tail || len == 0)
            pending_items.push_back({8'($urandom), 1'b0, 1'b1});
        msgs_sent++;
    endtask

    int lens [$];
    initial
    begin
        errors = 0;
        words_seen = 0;
        msgs_sent = 0;
        restart_digest();
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        byte_valid = 1'b0;
        last_item = 1'b0;
        out_ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, single bytes 00/ff, idle noise
        add_msg(0, 0, 1);
        pending_items.push_back({8'hff, 1'b0, 1'b0});
        add_msg(1, 0, 0);
        pending_items.push_back({8'h00, 1'b1, 1'b1});
        add_msg(1, 1, 1);
        add_msg(0, 0, 1);

        // length fits in the last block, spills into a new one, full block before padding
        lens = '{55, 56, 64};
        foreach (lens[i])
            add_msg(lens[i], 0, $urandom_range(0, 1));
        while (pending_items.size() < 270)
            add_msg($urandom_range(0, 12), $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);

        wait (pending_items.size() == 0 && in_valid == 1'b0);
        wait (expected_words.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d messages incl. empty, pad boundaries and multi-block; %0d words",
                 msgs_sent, words_seen);
        if (errors == 0 && expected_words.size() == 0)
            $display("** sha256_stream_hasher_top: PASSED **");
        else
            $display("** sha256_stream_hasher_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d words outstanding", expected_words.size());
        $display("** sha256_stream_hasher_top: FAILED **");
        $finish;
    end

endmodule
